// ===== hdl/euler_to_quaternion_top_assert.svh =====
// Assertion macros for the Euler-to-quaternion checker.
// Relies on clk and rst_n in the scope where a macro is used.
`ifndef EULER_TO_QUATERNION_TOP_ASSERT_SVH
`define EULER_TO_QUATERNION_TOP_ASSERT_SVH

// same-cycle implication
`define E2Q_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define E2Q_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/e2q_pkg.sv =====
// Shared types and constants for the Euler-to-quaternion pipeline.
// No dependencies.
package e2q_pkg;

    localparam int NUM_LANES = 3;
    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    localparam int QW = 32;

    localparam logic signed [QW-1:0] CORDIC_GAIN_Q30 = 32'sh26DD3B6A;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_Q30      = 64'sd3373259426;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
        32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic signed [QW-1:0] s;
        logic signed [QW-1:0] c;
    } sincos_t;

endpackage

// ===== hdl/e2q_cordic.sv =====
// Three-lane pipelined CORDIC: sine and cosine of half of each input angle, Q30.
// Depends on e2q_pkg.
module e2q_cordic #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       advance,
    input  logic                                       in_valid,
    input  logic [e2q_pkg::NUM_LANES-1:0][15:0]        angle,
    output logic                                       out_valid,
    output e2q_pkg::sincos_t [e2q_pkg::NUM_LANES-1:0]  sc
);
    import e2q_pkg::*;

    localparam int ZSH = 29 - ANGLE_FRAC_BITS;
    localparam int ZW  = (((47 - ANGLE_FRAC_BITS) > 34) ? (47 - ANGLE_FRAC_BITS) : 34) + 1;
    localparam logic signed [ZW-1:0] HALF_PI = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI_Q30);

    // stage 0 = folded angle, stage k = after k iterations, last bit = output stage
    logic [CORDIC_STAGES+1:0] valid_reg;

    logic signed [QW-1:0] x_reg   [CORDIC_STAGES+1][NUM_LANES];
    logic signed [QW-1:0] y_reg   [CORDIC_STAGES+1][NUM_LANES];
    logic signed [ZW-1:0] z_reg   [CORDIC_STAGES+1][NUM_LANES];
    logic                 neg_reg [CORDIC_STAGES+1][NUM_LANES];
    sincos_t [NUM_LANES-1:0] sc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[CORDIC_STAGES:0], in_valid};
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        logic signed [ZW-1:0] z_scaled;
        logic signed [ZW-1:0] z_fold_next;
        logic                 above;
        logic                 below;
        sincos_t              sc_next;

        assign z_scaled    = $signed({{(ZW-16){angle[l][15]}}, angle[l]}) <<< ZSH;
        assign above       = z_scaled > HALF_PI;
        assign below       = z_scaled < -HALF_PI;
        assign z_fold_next = above ? (z_scaled - PI_Z) :
                             below ? (z_scaled + PI_Z) : z_scaled;

        // fold into +-pi/2, remember the sign flip
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[0][l]   <= CORDIC_GAIN_Q30;
                y_reg[0][l]   <= '0;
                z_reg[0][l]   <= z_fold_next;
                neg_reg[0][l] <= above | below;
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_iter
            localparam logic signed [ZW-1:0] ATAN_Z = {{(ZW-32){1'b0}}, ATAN_Q30[i]};
            logic signed [QW-1:0] xs;
            logic signed [QW-1:0] ys;

            assign xs = x_reg[i][l] >>> i;
            assign ys = y_reg[i][l] >>> i;

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    if (!z_reg[i][l][ZW-1])
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] - ys;
                        y_reg[i+1][l] <= y_reg[i][l] + xs;
                        z_reg[i+1][l] <= z_reg[i][l] - ATAN_Z;
                    end
                    else
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] + ys;
                        y_reg[i+1][l] <= y_reg[i][l] - xs;
                        z_reg[i+1][l] <= z_reg[i][l] + ATAN_Z;
                    end
                    neg_reg[i+1][l] <= neg_reg[i][l];
                end
            end
        end

        assign sc_next.s = neg_reg[CORDIC_STAGES][l] ? -y_reg[CORDIC_STAGES][l]
                                                     :  y_reg[CORDIC_STAGES][l];
        assign sc_next.c = neg_reg[CORDIC_STAGES][l] ? -x_reg[CORDIC_STAGES][l]
                                                     :  x_reg[CORDIC_STAGES][l];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sc_reg[l] <= sc_next;
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES+1];
    assign sc        = sc_reg;

endmodule

// ===== hdl/e2q_quat.sv =====
// Quaternion assembly: pair products, triple products, sums, rounding and clamp.
// Depends on e2q_pkg.
module e2q_quat #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       advance,
    input  logic                                       in_valid,
    input  e2q_pkg::sincos_t [e2q_pkg::NUM_LANES-1:0]  sc,
    output logic                                       out_valid,
    output logic signed [15:0]                         quat_x,
    output logic signed [15:0]                         quat_y,
    output logic signed [15:0]                         quat_z,
    output logic signed [15:0]                         quat_w
);
    import e2q_pkg::*;

    localparam int SW = QW + 2;
    localparam longint ONE_L = longint'(1) << OUT_FRAC_BITS;
    localparam logic signed [SW-1:0] LIM_HI = SW'((ONE_L < 32767) ? ONE_L : 32767);
    localparam logic signed [SW-1:0] LIM_LO = SW'((ONE_L < 32768) ? -ONE_L : -32768);

    function automatic logic signed [QW-1:0] round_q30(input logic signed [2*QW-1:0] p);
        logic signed [2*QW-1:0] t;
        t = (p + (64'sd1 <<< 29)) >>> 30;
        return t[QW-1:0];
    endfunction

    logic [3:0] valid_reg;

    logic signed [QW-1:0] rc_reg;   // sr*cp
    logic signed [QW-1:0] cs_reg;   // cr*sp
    logic signed [QW-1:0] cc_reg;   // cr*cp
    logic signed [QW-1:0] ss_reg;   // sr*sp
    logic signed [QW-1:0] sy_reg;
    logic signed [QW-1:0] cy_reg;

    logic signed [QW-1:0] t_reg [8];
    logic signed [QW:0]   sum_reg [4];
    logic [3:0][15:0]     q_reg;

    logic signed [QW-1:0] sy, cy, sp, cp, sr, cr;

    assign sy = sc[LANE_YAW].s;
    assign cy = sc[LANE_YAW].c;
    assign sp = sc[LANE_PITCH].s;
    assign cp = sc[LANE_PITCH].c;
    assign sr = sc[LANE_ROLL].s;
    assign cr = sc[LANE_ROLL].c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // roll x pitch products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rc_reg <= round_q30(sr * cp);
            cs_reg <= round_q30(cr * sp);
            cc_reg <= round_q30(cr * cp);
            ss_reg <= round_q30(sr * sp);
            sy_reg <= sy;
            cy_reg <= cy;
        end
    end

    // times yaw
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_reg[0] <= round_q30(rc_reg * cy_reg);
            t_reg[1] <= round_q30(cs_reg * sy_reg);
            t_reg[2] <= round_q30(cs_reg * cy_reg);
            t_reg[3] <= round_q30(rc_reg * sy_reg);
            t_reg[4] <= round_q30(cc_reg * sy_reg);
            t_reg[5] <= round_q30(ss_reg * cy_reg);
            t_reg[6] <= round_q30(cc_reg * cy_reg);
            t_reg[7] <= round_q30(ss_reg * sy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg[0] <= {t_reg[0][QW-1], t_reg[0]} - {t_reg[1][QW-1], t_reg[1]};
            sum_reg[1] <= {t_reg[2][QW-1], t_reg[2]} + {t_reg[3][QW-1], t_reg[3]};
            sum_reg[2] <= {t_reg[4][QW-1], t_reg[4]} - {t_reg[5][QW-1], t_reg[5]};
            sum_reg[3] <= {t_reg[6][QW-1], t_reg[6]} + {t_reg[7][QW-1], t_reg[7]};
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_out
        logic signed [SW-1:0] wide;
        logic signed [SW-1:0] rounded;
        logic [15:0]          q_next;

        assign wide = {sum_reg[k][QW], sum_reg[k]};

        if (OUT_FRAC_BITS < 30)
        begin : g_round
            localparam int SH = 30 - OUT_FRAC_BITS;
            localparam logic signed [SW-1:0] HALF = SW'(longint'(1) << (SH - 1));
            assign rounded = (wide + HALF) >>> SH;
        end
        else
        begin : g_pass
            assign rounded = wide;
        end

        assign q_next = (rounded > LIM_HI) ? LIM_HI[15:0] :
                        (rounded < LIM_LO) ? LIM_LO[15:0] : rounded[15:0];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                q_reg[k] <= q_next;
            end
        end
    end

    assign out_valid = valid_reg[3];
    assign quat_x    = q_reg[0];
    assign quat_y    = q_reg[1];
    assign quat_z    = q_reg[2];
    assign quat_w    = q_reg[3];

endmodule

// ===== hdl/euler_to_quaternion_top.sv =====
// ZYX Euler attitude (yaw, pitch, roll) to unit quaternion, fully pipelined.
// Depends on e2q_pkg, e2q_cordic and e2q_quat.
//
// Takes one angle word per clock and gives one quaternion word per clock, while not
// stalled. It holds one fold stage, one CORDIC iteration per stage, a sign stage, two
// multiplier stages, a sum stage and the output register.
// Angles are Q.ANGLE_FRAC_BITS radians, results Q1.OUT_FRAC_BITS clamped to +-1.
// The pipeline advances as a whole; while a finished quaternion word is held by
// quat_stall, angle_stall is raised and nothing moves, otherwise a word is taken
// every cycle.
module euler_to_quaternion_top #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int OUT_FRAC_BITS   = 14,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angle_valid,
    output logic               angle_stall,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] roll_angle,
    output logic               quat_valid,
    input  logic               quat_stall,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w
);
    import e2q_pkg::*;

    logic                          advance;
    logic [NUM_LANES-1:0][15:0]    angle;
    logic                          sc_valid;
    sincos_t [NUM_LANES-1:0]       sc;

    assign advance     = !quat_valid || !quat_stall;
    assign angle_stall = !advance;

    assign angle[LANE_YAW]   = yaw_angle;
    assign angle[LANE_PITCH] = pitch_angle;
    assign angle[LANE_ROLL]  = roll_angle;

    e2q_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (angle_valid),
        .angle     (angle),
        .out_valid (sc_valid),
        .sc        (sc)
    );

    e2q_quat #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_quat (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sc_valid),
        .sc        (sc),
        .out_valid (quat_valid),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w)
    );

endmodule

// ===== hdl/e2q_checker.sv =====
// Port-level checks for euler_to_quaternion_top, bound to every instance.
// Depends on euler_to_quaternion_top_assert.svh.
`include "euler_to_quaternion_top_assert.svh"

module e2q_checker #(
    parameter int OUT_FRAC_BITS = 14
) (
    input logic               clk,
    input logic               rst_n,
    input logic               angle_stall,
    input logic               quat_valid,
    input logic               quat_stall,
    input logic signed [15:0] quat_x,
    input logic signed [15:0] quat_y,
    input logic signed [15:0] quat_z,
    input logic signed [15:0] quat_w
);

    localparam longint ONE_L = longint'(1) << OUT_FRAC_BITS;
    localparam int HI = int'((ONE_L < 32767) ? ONE_L : 32767);
    localparam int LO = int'((ONE_L < 32768) ? -ONE_L : -32768);

    `E2Q_ASSERT_NXT(a_hold_word, quat_valid && quat_stall, quat_valid && $stable(quat_x) && $stable(quat_y) && $stable(quat_z) && $stable(quat_w), "stalled quaternion word changed")

    `E2Q_ASSERT_IMP(a_free_when_empty, !quat_valid, !angle_stall, "input stalled with empty output")

    `E2Q_ASSERT_IMP(a_stall_cause, angle_stall, quat_valid && quat_stall, "input stalled without output back-pressure")

    `E2Q_ASSERT_IMP(a_unit_range, quat_valid, quat_x >= LO && quat_x <= HI && quat_y >= LO && quat_y <= HI && quat_z >= LO && quat_z <= HI && quat_w >= LO && quat_w <= HI, "quaternion component beyond one")

endmodule

bind euler_to_quaternion_top e2q_checker #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_e2q_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .angle_stall (angle_stall),
    .quat_valid  (quat_valid),
    .quat_stall  (quat_stall),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .quat_w      (quat_w)
);
